FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define ASSERT_CHECK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: property does not hold");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_CHECK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

FILE: hdl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Types and constants of the battery trend and status monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

   localparam int ADC_W      = 12;
   localparam int TIME_W     = 32;
   localparam int MV_W       = 16;
   localparam int RATIO_W    = 12;
   localparam int STREAK_W   = 8;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W     = ADC_W + RATIO_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIVIDER_RATIO = 3'd0,
      CSR_TREND_INTERVAL = 3'd1,
      CSR_RISE_THRESHOLD = 3'd2,
      CSR_STREAK_NEEDED = 3'd3,
      CSR_ABSENT_BELOW = 3'd4,
      CSR_CHARGE_CEILING = 3'd5,
      CSR_LOW_BELOW = 3'd6,
      CSR_HALF_BELOW = 3'd7
   } csr_index_type;

   localparam logic [RATIO_W-1:0]  RST_DIVIDER_RATIO  = 12'd512;
   localparam logic [TIME_W-1:0]   RST_TREND_INTERVAL = 32'd30000;
   localparam logic [MV_W-1:0]     RST_RISE_THRESHOLD = 16'd8;
   localparam logic [STREAK_W-1:0] RST_STREAK_NEEDED  = 8'd2;
   localparam logic [MV_W-1:0]     RST_ABSENT_BELOW   = 16'd1000;
   localparam logic [MV_W-1:0]     RST_CHARGE_CEILING = 16'd4150;
   localparam logic [MV_W-1:0]     RST_LOW_BELOW      = 16'd3400;
   localparam logic [MV_W-1:0]     RST_HALF_BELOW     = 16'd3900;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ABSENT = 3'd0,
      STATUS_CHARGING = 3'd1,
      STATUS_LOW = 3'd2,
      STATUS_HALF = 3'd3,
      STATUS_FULL = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SUM,
      STATE_DIV,
      STATE_EVAL
   } bts_state_type;

   typedef struct packed {
      logic [RATIO_W-1:0]  divider_ratio;
      logic [TIME_W-1:0]   trend_interval;
      logic [MV_W-1:0]     rise_threshold;
      logic [STREAK_W-1:0] streak_needed;
      logic [MV_W-1:0]     absent_below;
      logic [MV_W-1:0]     charge_ceiling;
      logic [MV_W-1:0]     low_below;
      logic [MV_W-1:0]     half_below;
   } bts_cfg_type;

   typedef struct packed {
      logic              go;
      logic [MV_W-1:0]   mean;
      logic [TIME_W-1:0] now_ms;
   } trend_req_type;

   typedef struct packed {
      logic trend_up;
      logic evaluated;
   } trend_rsp_type;

endpackage

`default_nettype wire

FILE: hdl/bts_if.sv
// ----------------------------------------------------------------------------
// bts_req_if / bts_rsp_if
// Valid/ready channels for samples in and status results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bts_req_if;
   import bts_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADC_W-1:0]  adc_mv;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, adc_mv, now_ms, input ready);
   modport sink (input valid, adc_mv, now_ms, output ready);
endinterface

interface bts_rsp_if;
   import bts_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [MV_W-1:0]     battery_mv;
   logic [MV_W-1:0]     smoothed_mv;
   logic                rising_trend;
   logic                trend_evaluated;

   modport source (output valid, status, battery_mv, smoothed_mv, rising_trend,
                   trend_evaluated, input ready);
   modport sink (input valid, status, battery_mv, smoothed_mv, rising_trend,
                 trend_evaluated, output ready);
endinterface

`default_nettype wire

FILE: hdl/bts_ram.sv
// ----------------------------------------------------------------------------
// bts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 6,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/bts_div.sv
// ----------------------------------------------------------------------------
// bts_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_div #(
   parameter int NUM_W = 19,
   parameter int DEN_W = 3
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});
   assign done  = busy_ff && (cnt_ff == CNT_W'(NUM_W));
   assign quot  = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // shift in one quotient bit per step, keep the partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff && !done) begin
         rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

endmodule

`default_nettype wire

FILE: hdl/bts_trend.sv
// ----------------------------------------------------------------------------
// bts_trend
// Baseline, window timer and rise/fall streaks behind the rising trend.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_trend (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bts_pkg::bts_cfg_type   cfg,
   input  wire bts_pkg::trend_req_type req,
   output bts_pkg::trend_rsp_type      rsp
);
   import bts_pkg::*;

   logic [MV_W-1:0]     baseline_ff, baseline_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic                started_ff;
   logic [STREAK_W-1:0] rise_ff, rise_in;
   logic [STREAK_W-1:0] fall_ff, fall_in;
   logic                trend_ff, trend_in;
   logic [TIME_W-1:0]   elapsed;
   logic [MV_W:0]       rise_limit;
   logic                closes;
   logic                rising;
   logic [STREAK_W-1:0] rise_inc;
   logic [STREAK_W-1:0] fall_inc;

   assign elapsed    = req.now_ms - start_ff;
   assign closes     = started_ff && (elapsed > cfg.trend_interval);
   // mean - baseline > threshold, kept unsigned
   assign rise_limit = {1'b0, baseline_ff} + {1'b0, cfg.rise_threshold};
   assign rising     = ({1'b0, req.mean} > rise_limit);
   assign rise_inc   = (rise_ff == '1) ? rise_ff : rise_ff + 1'b1;
   assign fall_inc   = (fall_ff == '1) ? fall_ff : fall_ff + 1'b1;

   always_comb begin
      baseline_in = baseline_ff;
      start_in    = start_ff;
      rise_in     = rise_ff;
      fall_in     = fall_ff;
      trend_in    = trend_ff;
      if (!started_ff || closes) begin
         baseline_in = req.mean;
         start_in    = req.now_ms;
      end
      if (closes) begin
         if (rising) begin
            rise_in = rise_inc;
            fall_in = '0;
            if (rise_inc >= cfg.streak_needed) begin
               trend_in = 1'b1;
            end
         end else begin
            fall_in = fall_inc;
            rise_in = '0;
            if (fall_inc >= cfg.streak_needed) begin
               trend_in = 1'b0;
            end
         end
      end
   end

   assign rsp.trend_up  = trend_in;
   assign rsp.evaluated = closes;

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff <= '0;
         start_ff    <= '0;
         started_ff  <= 1'b0;
         rise_ff     <= '0;
         fall_ff     <= '0;
         trend_ff    <= 1'b0;
      end else if (req.go) begin
         baseline_ff <= baseline_in;
         start_ff    <= start_in;
         started_ff  <= 1'b1;
         rise_ff     <= rise_in;
         fall_ff     <= fall_in;
         trend_ff    <= trend_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/battery_trend_status_monitor.sv
// ----------------------------------------------------------------------------
// battery_trend_status_monitor
// Scales converter readings, averages them in a sample ring and tracks trend.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one converter reading (adc_mv) and the time (now_ms) per
//   transaction; rsp_bus returns exactly one result per request: status code,
//   scaled voltage, ring mean, rising trend and a window-closed flag.
//   csr_we writes one configuration register a cycle; the user must do so
//   only while idle; the block itself does not enforce it. Timing: one
//   request at a time. The bit-serial divider forms the mean from the ring
//   sum, SUM_W = 16 + clog2(WINDOW) bits wide, after a registered read of
//   the sample ring RAM; the result then enters the output register. A new
//   request is taken once the last result has entered the output register,
//   even while it waits there; if the receiver stalls, the next result holds
//   in the final stage. Reset restores the register defaults and empties the
//   ring (fill count zero) with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module battery_trend_status_monitor #(
   parameter int WINDOW = 6
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bts_req_if.sink                                req_bus,
   bts_rsp_if.source                              rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [bts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bts_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bts_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = MV_W + $clog2(WINDOW);

   bts_cfg_type        cfg_ff;
   bts_state_type      state_ff, state_in;
   logic               req_ready;
   logic               req_fire;
   logic               ram_we;
   logic               div_start;
   logic               div_done;
   logic               out_load;
   logic               out_free;

   logic [PROD_W-1:0]  product;
   logic [MV_W-1:0]    mv_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [SLOT_W-1:0]  slot_ff, slot_next;
   logic [CNT_W-1:0]   fill_ff, fill_next;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [MV_W-1:0]    ram_rdata;
   logic [MV_W-1:0]    evicted;
   logic [SUM_W-1:0]   quot;
   logic [MV_W-1:0]    mean;

   trend_req_type      trend_req;
   trend_rsp_type      trend_rsp;
   status_type         status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff;
   logic [MV_W-1:0]    battery_ff;
   logic [MV_W-1:0]    smoothed_ff;
   logic               rising_ff;
   logic               evaluated_ff;

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.divider_ratio  <= RST_DIVIDER_RATIO;
         cfg_ff.trend_interval <= RST_TREND_INTERVAL;
         cfg_ff.rise_threshold <= RST_RISE_THRESHOLD;
         cfg_ff.streak_needed  <= RST_STREAK_NEEDED;
         cfg_ff.absent_below   <= RST_ABSENT_BELOW;
         cfg_ff.charge_ceiling <= RST_CHARGE_CEILING;
         cfg_ff.low_below      <= RST_LOW_BELOW;
         cfg_ff.half_below     <= RST_HALF_BELOW;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DIVIDER_RATIO: begin
               cfg_ff.divider_ratio <= csr_wdata[RATIO_W-1:0];
            end
            CSR_TREND_INTERVAL: begin
               cfg_ff.trend_interval <= csr_wdata[TIME_W-1:0];
            end
            CSR_RISE_THRESHOLD: begin
               cfg_ff.rise_threshold <= csr_wdata[MV_W-1:0];
            end
            CSR_STREAK_NEEDED: begin
               cfg_ff.streak_needed <= csr_wdata[STREAK_W-1:0];
            end
            CSR_ABSENT_BELOW: begin
               cfg_ff.absent_below <= csr_wdata[MV_W-1:0];
            end
            CSR_CHARGE_CEILING: begin
               cfg_ff.charge_ceiling <= csr_wdata[MV_W-1:0];
            end
            CSR_LOW_BELOW: begin
               cfg_ff.low_below <= csr_wdata[MV_W-1:0];
            end
            CSR_HALF_BELOW: begin
               cfg_ff.half_below <= csr_wdata[MV_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- sequencer ----------------
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire = req_bus.valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ram_we    = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         STATE_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               state_in = STATE_SUM;
            end
         end
         STATE_SUM: begin
            ram_we    = 1'b1;
            div_start = 1'b1;
            state_in  = STATE_DIV;
         end
         STATE_DIV: begin
            if (div_done) begin
               state_in = STATE_EVAL;
            end
         end
         STATE_EVAL: begin
            // hold the finished result until the output register frees up
            if (out_free) begin
               out_load = 1'b1;
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_bus.ready = req_ready;

   // ---------------- sample path ----------------
   // Q4.8 scaling; the 24-bit product shifted by 8 always fits 16 bits
   assign product = {{RATIO_W{1'b0}}, req_bus.adc_mv} * {{ADC_W{1'b0}}, cfg_ff.divider_ratio};

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mv_ff  <= product[PROD_W-1:PROD_W-MV_W];
         now_ff <= req_bus.now_ms;
      end
   end

   bts_ram #(
      .WIDTH (MV_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (mv_ff),
      .rd_addr (slot_ff),
      .rd_data (ram_rdata)
   );

   // drop the overwritten sample from the running sum once the ring is full
   assign evicted   = (fill_ff == CNT_W'(WINDOW)) ? ram_rdata : '0;
   assign sum_in    = sum_ff - SUM_W'(evicted) + SUM_W'(mv_ff);
   assign slot_next = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
   assign fill_next = (fill_ff == CNT_W'(WINDOW)) ? fill_ff : fill_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else if (ram_we) begin
         slot_ff <= slot_next;
         fill_ff <= fill_next;
         sum_ff  <= sum_in;
      end
   end

   bts_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sum_in),
      .den   (fill_next),
      .done  (div_done),
      .quot  (quot)
   );

   assign mean = quot[MV_W-1:0];

   // ---------------- trend ----------------
   assign trend_req.go     = out_load;
   assign trend_req.mean   = mean;
   assign trend_req.now_ms = now_ff;

   bts_trend u_trend (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (trend_req),
      .rsp   (trend_rsp)
   );

   always_comb begin
      if (mv_ff < cfg_ff.absent_below) begin
         status_in = STATUS_ABSENT;
      end else if (trend_rsp.trend_up && (mv_ff < cfg_ff.charge_ceiling)) begin
         status_in = STATUS_CHARGING;
      end else if (mv_ff < cfg_ff.low_below) begin
         status_in = STATUS_LOW;
      end else if (mv_ff < cfg_ff.half_below) begin
         status_in = STATUS_HALF;
      end else begin
         status_in = STATUS_FULL;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         status_ff    <= status_in;
         battery_ff   <= mv_ff;
         smoothed_ff  <= mean;
         rising_ff    <= trend_rsp.trend_up;
         evaluated_ff <= trend_rsp.evaluated;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = status_ff;
   assign rsp_bus.battery_mv      = battery_ff;
   assign rsp_bus.smoothed_mv     = smoothed_ff;
   assign rsp_bus.rising_trend    = rising_ff;
   assign rsp_bus.trend_evaluated = evaluated_ff;

   // ---------------- assertions ----------------
   `ASSERT_CHECK(a_accept_to_sum, clock, reset, req_fire |=> state_ff == STATE_SUM)
   `ASSERT_CHECK(a_fill_bound, clock, reset, fill_ff <= CNT_W'(WINDOW))
   `ASSERT_NEVER(a_slot_range, clock, reset, slot_ff > SLOT_W'(WINDOW - 1))
   `ASSERT_CHECK(a_done_in_div, clock, reset, div_done |-> state_ff == STATE_DIV)
   `ASSERT_CHECK(a_load_sets_valid, clock, reset, out_load |=> rsp_valid_ff)

endmodule

`default_nettype wire

FILE: sim/bts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_checker
// Passive scoreboard for the battery trend and status monitor: tracks the
// register writes, predicts one result per accepted sample and compares each
// returned result against the oldest prediction.
// ----------------------------------------------------------------------------
module bts_checker #(
   parameter int WINDOW = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   bts_req_if                                req_bus,
   bts_rsp_if                                rsp_bus,
   input  logic                              csr_we,
   input  logic [bts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bts_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                mismatches,
   output int                                pending,
   output int                                checked,
   output int                                windows_closed
);
   import bts_pkg::*;

   typedef struct packed {
      status_type          status;
      logic [MV_W-1:0]     battery_mv;
      logic [MV_W-1:0]     smoothed_mv;
      logic                rising_trend;
      logic                trend_evaluated;
   } gauge_result_type;

   bts_cfg_type         cfg;
   logic [MV_W-1:0]     mv_ring [WINDOW];
   int unsigned         ring_slot;
   int unsigned         ring_fill;
   logic [MV_W-1:0]     baseline_mv;
   logic [TIME_W-1:0]   window_start_ms;
   logic                started;
   logic [STREAK_W-1:0] rise_streak;
   logic [STREAK_W-1:0] fall_streak;
   logic                trend_up;

   gauge_result_type    gauge_expect_q [$];
   int                  error_count = 0;
   int                  result_count = 0;
   int                  window_count = 0;

   task automatic report_mismatch(input string what);
      $display("ERROR %0t: %s", $time, what);
      error_count++;
   endtask

   // advance the gauge state by one sample and return the result it yields
   function automatic gauge_result_type predict_gauge(input logic [ADC_W-1:0] adc,
                                                      input logic [TIME_W-1:0] now);
      int unsigned       scaled;
      int unsigned       ring_sum;
      logic [MV_W-1:0]   mv;
      logic [MV_W-1:0]   mean;
      logic [TIME_W-1:0] elapsed;
      logic              closed;
      gauge_result_type  r;

      scaled = (32'(adc) * 32'(cfg.divider_ratio)) >> 8;
      mv = (scaled > 32'd65535) ? 16'hFFFF : MV_W'(scaled);

      if (ring_slot >= WINDOW) ring_slot = 0;
      mv_ring[ring_slot] = mv;
      ring_slot = (ring_slot + 1) % WINDOW;
      if (ring_fill < WINDOW) ring_fill++;
      ring_sum = 0;
      for (int i = 0; i < ring_fill; i++) ring_sum += mv_ring[i];
      mean = MV_W'(ring_sum / ring_fill);

      closed = 1'b0;
      elapsed = now - window_start_ms;
      if (!started) begin
         baseline_mv = mean;
         window_start_ms = now;
         started = 1'b1;
      end else if (elapsed > cfg.trend_interval) begin
         if (int'(mean) - int'(baseline_mv) > int'(cfg.rise_threshold)) begin
            if (rise_streak != 8'hFF) rise_streak++;
            fall_streak = '0;
            if (rise_streak >= cfg.streak_needed) trend_up = 1'b1;
         end else begin
            if (fall_streak != 8'hFF) fall_streak++;
            rise_streak = '0;
            if (fall_streak >= cfg.streak_needed) trend_up = 1'b0;
         end
         baseline_mv = mean;
         window_start_ms = now;
         closed = 1'b1;
         window_count++;
      end

      if (mv < cfg.absent_below)                   r.status = STATUS_ABSENT;
      else if (trend_up && mv < cfg.charge_ceiling) r.status = STATUS_CHARGING;
      else if (mv < cfg.low_below)                 r.status = STATUS_LOW;
      else if (mv < cfg.half_below)                r.status = STATUS_HALF;
      else                                         r.status = STATUS_FULL;
      r.battery_mv = mv;
      r.smoothed_mv = mean;
      r.rising_trend = trend_up;
      r.trend_evaluated = closed;
      return r;
   endfunction

   always @(posedge clock) begin
      gauge_result_type want;
      if (reset) begin
         cfg.divider_ratio = RST_DIVIDER_RATIO;
         cfg.trend_interval = RST_TREND_INTERVAL;
         cfg.rise_threshold = RST_RISE_THRESHOLD;
         cfg.streak_needed = RST_STREAK_NEEDED;
         cfg.absent_below = RST_ABSENT_BELOW;
         cfg.charge_ceiling = RST_CHARGE_CEILING;
         cfg.low_below = RST_LOW_BELOW;
         cfg.half_below = RST_HALF_BELOW;
         for (int i = 0; i < WINDOW; i++) mv_ring[i] = '0;
         ring_slot = 0;
         ring_fill = 0;
         baseline_mv = '0;
         window_start_ms = '0;
         started = 1'b0;
         rise_streak = '0;
         fall_streak = '0;
         trend_up = 1'b0;
         gauge_expect_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DIVIDER_RATIO:  cfg.divider_ratio = csr_wdata[RATIO_W-1:0];
               CSR_TREND_INTERVAL: cfg.trend_interval = csr_wdata[TIME_W-1:0];
               CSR_RISE_THRESHOLD: cfg.rise_threshold = csr_wdata[MV_W-1:0];
               CSR_STREAK_NEEDED:  cfg.streak_needed = csr_wdata[STREAK_W-1:0];
               CSR_ABSENT_BELOW:   cfg.absent_below = csr_wdata[MV_W-1:0];
               CSR_CHARGE_CEILING: cfg.charge_ceiling = csr_wdata[MV_W-1:0];
               CSR_LOW_BELOW:      cfg.low_below = csr_wdata[MV_W-1:0];
               CSR_HALF_BELOW:     cfg.half_below = csr_wdata[MV_W-1:0];
               default: ;
            endcase
         end

         // a result can never belong to a sample taken at the same edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (gauge_expect_q.size() == 0) begin
               report_mismatch($sformatf("result with no sample pending, status %0d mv %0d",
                                         rsp_bus.status, rsp_bus.battery_mv));
            end else begin
               want = gauge_expect_q.pop_front();
               result_count++;
               if (rsp_bus.status !== want.status)
                  report_mismatch($sformatf("status: got %0d, expected %0d",
                                            rsp_bus.status, want.status));
               if (rsp_bus.battery_mv !== want.battery_mv)
                  report_mismatch($sformatf("battery_mv: got %0d, expected %0d",
                                            rsp_bus.battery_mv, want.battery_mv));
               if (rsp_bus.smoothed_mv !== want.smoothed_mv)
                  report_mismatch($sformatf("smoothed_mv: got %0d, expected %0d",
                                            rsp_bus.smoothed_mv, want.smoothed_mv));
               if (rsp_bus.rising_trend !== want.rising_trend)
                  report_mismatch($sformatf("rising_trend: got %0b, expected %0b",
                                            rsp_bus.rising_trend, want.rising_trend));
               if (rsp_bus.trend_evaluated !== want.trend_evaluated)
                  report_mismatch($sformatf("trend_evaluated: got %0b, expected %0b",
                                            rsp_bus.trend_evaluated, want.trend_evaluated));
            end
         end

         if (req_bus.valid && req_bus.ready)
            gauge_expect_q.push_back(predict_gauge(req_bus.adc_mv, req_bus.now_ms));
      end

      pending <= gauge_expect_q.size();
      mismatches <= error_count;
      checked <= result_count;
      windows_closed <= window_count;
   end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top-level testbench of the battery trend and status monitor. Runs a directed
// sample sequence under reset defaults, then random sample streams shaped as
// voltage ramps over several register settings, with random gaps on both
// channels; bts_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
   import bts_pkg::*;

   localparam int WINDOW = 6;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int pending;
   int checked;
   int windows_closed;

   int unsigned       samples_sent = 0;
   int unsigned       settings_applied = 1;
   int unsigned       send_calm = 0;
   int unsigned       drain_calm = 0;
   int                trend_level = 2048;
   int                trend_slope = 12;
   logic [TIME_W-1:0] sim_now_ms;
   bts_cfg_type       active_cfg;

   // directed samples: reading and time offset from a start just below the wrap
   int unsigned dir_adc [20] = '{2000, 0, 4095, 2000, 2043, 4095, 4095, 2000, 1600, 499,
                                 500, 2075, 2074, 0, 0, 1699, 1700, 1949, 1950, 4095};
   int unsigned dir_dt [20] = '{0, 100, 30000, 30001, 60002, 90003, 120004, 120010,
                                120020, 120030, 120040, 120050, 120060, 150100, 180200,
                                180210, 180220, 180230, 180240, 32'h8000_0000};

   bts_req_if req_bus ();
   bts_rsp_if rsp_bus ();

   battery_trend_status_monitor #(.WINDOW(WINDOW)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bts_checker #(.WINDOW(WINDOW)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .pending        (pending),
      .checked        (checked),
      .windows_closed (windows_closed)
   );

   always #5 clock = ~clock;

   initial begin : watchdog
      #5ms;
      $display("Timeout: monitor stopped making progress");
      $display("Mismatches found");
      $finish;
   end

   // pick a random wait, with occasional stretches of no waiting at all
   task automatic draw_wait(inout int unsigned calm, output int cycles);
      if (calm > 0) begin
         calm--;
         cycles = 0;
      end else begin
         if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 30);
         cycles = $urandom_range(0, 7);
      end
   endtask

   initial begin : drain
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_bus.valid && rsp_bus.ready) begin
            draw_wait(drain_calm, hold);
            rsp_bus.ready <= (hold == 0);
         end else if (!rsp_bus.ready) begin
            if (hold > 0) hold--;
            rsp_bus.ready <= (hold == 0);
         end
      end
   end

   // call at a rising edge; returns at the edge that accepts the transaction
   task automatic send_sample(input logic [ADC_W-1:0] adc, input logic [TIME_W-1:0] now);
      int gap;
      draw_wait(send_calm, gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.adc_mv <= adc;
      req_bus.now_ms <= now;
      do @(posedge clock); while (!req_bus.ready);
      samples_sent++;
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_setting(input bts_cfg_type s);
      req_bus.valid <= 1'b0;
      wait_idle();
      write_reg(CSR_DIVIDER_RATIO, CSR_DATA_W'(s.divider_ratio));
      write_reg(CSR_TREND_INTERVAL, CSR_DATA_W'(s.trend_interval));
      write_reg(CSR_RISE_THRESHOLD, CSR_DATA_W'(s.rise_threshold));
      write_reg(CSR_STREAK_NEEDED, CSR_DATA_W'(s.streak_needed));
      write_reg(CSR_ABSENT_BELOW, CSR_DATA_W'(s.absent_below));
      write_reg(CSR_CHARGE_CEILING, CSR_DATA_W'(s.charge_ceiling));
      write_reg(CSR_LOW_BELOW, CSR_DATA_W'(s.low_below));
      write_reg(CSR_HALF_BELOW, CSR_DATA_W'(s.half_below));
      csr_we <= 1'b0;
      active_cfg = s;
      settings_applied++;
   endtask

   function automatic bts_cfg_type cfg_of(input logic [RATIO_W-1:0] ratio,
                                          input logic [TIME_W-1:0] interval,
                                          input logic [MV_W-1:0] rise,
                                          input logic [STREAK_W-1:0] streak,
                                          input logic [MV_W-1:0] absent_mv,
                                          input logic [MV_W-1:0] ceiling_mv,
                                          input logic [MV_W-1:0] low_mv,
                                          input logic [MV_W-1:0] half_mv);
      bts_cfg_type s;
      s.divider_ratio = ratio;
      s.trend_interval = interval;
      s.rise_threshold = rise;
      s.streak_needed = streak;
      s.absent_below = absent_mv;
      s.charge_ceiling = ceiling_mv;
      s.low_below = low_mv;
      s.half_below = half_mv;
      return s;
   endfunction

   // mostly jittered ramps, some raw noise; time steps mostly up to a quarter interval
   task automatic run_random(input int unsigned count);
      logic [ADC_W-1:0]  adc;
      logic [TIME_W-1:0] time_span;
      int                jitter;
      int unsigned       n;
      time_span = (active_cfg.trend_interval > 32'h4000_0000) ? 32'h4000_0000
                                                              : active_cfg.trend_interval >> 2;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 14) == 0) begin
            trend_slope = int'($urandom_range(0, 120)) - 60;
            if ($urandom_range(0, 2) == 0) trend_level = $urandom_range(0, 4095);
         end
         trend_level += trend_slope;
         if (trend_level > 4095) begin
            trend_level = 4095;
            trend_slope = -trend_slope;
         end else if (trend_level < 0) begin
            trend_level = 0;
            trend_slope = -trend_slope;
         end

         if ($urandom_range(0, 4) == 0) begin
            adc = ADC_W'($urandom_range(0, 4095));
         end else begin
            jitter = trend_level + int'($urandom_range(0, 16)) - 8;
            if (jitter < 0) jitter = 0;
            if (jitter > 4095) jitter = 4095;
            adc = ADC_W'(jitter);
         end

         case ($urandom_range(0, 9))
            0:       sim_now_ms += active_cfg.trend_interval;
            1:       sim_now_ms += active_cfg.trend_interval + 1;
            2:       sim_now_ms = $urandom;
            default: sim_now_ms += $urandom_range(0, time_span);
         endcase
         send_sample(adc, sim_now_ms);
      end
   endtask

   initial begin : stimulus
      logic [TIME_W-1:0] t0;
      logic [TIME_W-1:0] interval;
      logic [MV_W-1:0]   absent_mv;
      logic [MV_W-1:0]   low_mv;
      bts_cfg_type       setting;
      int                phase;
      int                k;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.adc_mv = '0;
      req_bus.now_ms = '0;
      csr_we = 1'b0;
      csr_index = CSR_DIVIDER_RATIO;
      csr_wdata = '0;
      active_cfg = cfg_of(RST_DIVIDER_RATIO, RST_TREND_INTERVAL, RST_RISE_THRESHOLD,
                          RST_STREAK_NEEDED, RST_ABSENT_BELOW, RST_CHARGE_CEILING,
                          RST_LOW_BELOW, RST_HALF_BELOW);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: first sample, exact interval, wrap, rise equal to the
      // threshold, trend set and cleared, every status boundary
      t0 = 32'hFFFF_F000;
      for (k = 0; k < 20; k++) send_sample(ADC_W'(dir_adc[k]), t0 + dir_dt[k]);
      sim_now_ms = t0 + dir_dt[19];

      apply_setting(cfg_of(12'd256, 32'd40, 16'd4, 8'd1, 16'd200, 16'd3500, 16'd1500,
                           16'd2800));
      run_random(200);

      // largest values everywhere but the trend interval, which is 1
      apply_setting(cfg_of(12'd4095, 32'd1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                           16'hFFFF, 16'hFFFF));
      run_random(60);

      // smallest levels, ratio and streak of one; the interval can never be exceeded
      apply_setting(cfg_of(12'd1, 32'hFFFF_FFFF, 16'd0, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0));
      run_random(60);

      // streak of zero sets the trend from every closed window
      apply_setting(cfg_of(12'd300, 32'd25, 16'd0, 8'd0, 16'd300, 16'd4000, 16'd1800,
                           16'd3200));
      run_random(100);

      // divider ratio of zero with no absent level
      apply_setting(cfg_of(12'd0, 32'd10, 16'd1, 8'd2, 16'd0, 16'd100, 16'd0, 16'd0));
      run_random(30);

      for (phase = 0; phase < 5; phase++) begin
         case ($urandom_range(0, 2))
            0:       interval = $urandom_range(1, 60);
            1:       interval = $urandom_range(61, 20000);
            default: interval = $urandom;
         endcase
         absent_mv = $urandom_range(0, 1500);
         low_mv = absent_mv + MV_W'($urandom_range(0, 3000));
         if (phase == 4)
            setting = cfg_of(RATIO_W'($urandom), interval, MV_W'($urandom),
                             STREAK_W'($urandom), MV_W'($urandom), MV_W'($urandom),
                             MV_W'($urandom), MV_W'($urandom));
         else
            setting = cfg_of(RATIO_W'($urandom_range(1, 4095)), interval,
                             MV_W'($urandom_range(0, 40)), STREAK_W'($urandom_range(1, 4)),
                             absent_mv, MV_W'($urandom_range(0, 9000)), low_mv,
                             low_mv + MV_W'($urandom_range(0, 3000)));
         apply_setting(setting);
         run_random(80);
      end

      req_bus.valid <= 1'b0;
      wait_idle();
      repeat (40) @(posedge clock);

      $display("Sent %0d samples under %0d register settings", samples_sent,
               settings_applied);
      $display("Checked %0d results, %0d of them closed a trend window", checked,
               windows_closed);
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
